FILE: src/swm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window minimum block
// Holds the field widths, the controller states, the layout of one deque
// entry and the result item.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned CFG_W  = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK
  } state_e;

  // One deque entry: sample value and its position in the stream.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic        [POS_W-1:0]  pos;
  } entry_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_min;
    logic                     window_empty;
  } result_t;

endpackage : swm_pkg

`default_nettype wire

FILE: src/swm_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_mem: deque storage
// One write port and two registered read ports, one for the front of the
// deque and one for its back. Read data appear in the cycle after the request.
// ----------------------------------------------------------------------------
module swm_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire swm_pkg::entry_t  wdata_i,
  input  wire logic             re_a_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output swm_pkg::entry_t       rdata_a_o,
  input  wire logic             re_b_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output swm_pkg::entry_t       rdata_b_o
);

  swm_pkg::entry_t mem_q [DEPTH];
  swm_pkg::entry_t rdata_a_q;
  swm_pkg::entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule : swm_mem

`default_nettype wire

FILE: src/swm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ctrl: deque sequencer
// Forms the result of an item from the cached front entry, then drops
// expired entries from the front, drops back entries not below the new
// sample and appends it, all through the deque memory.
// ----------------------------------------------------------------------------
module swm_ctrl #(
  parameter int unsigned MAX_WINDOW = 1024,
  parameter int unsigned AW         = 10,
  parameter int unsigned CW         = 11
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [CW-1:0]                      win_len_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [swm_pkg::DATA_W-1:0]  sample_i,
  input  wire logic                               end_of_stream_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output swm_pkg::result_t                        result_o,
  output logic                                    mem_we_o,
  output logic [AW-1:0]                           mem_waddr_o,
  output swm_pkg::entry_t                         mem_wdata_o,
  output logic                                    mem_re_a_o,
  output logic [AW-1:0]                           mem_raddr_a_o,
  input  wire swm_pkg::entry_t                    mem_rdata_a_i,
  output logic                                    mem_re_b_o,
  output logic [AW-1:0]                           mem_raddr_b_o,
  input  wire swm_pkg::entry_t                    mem_rdata_b_i
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] FULL      = CW'(MAX_WINDOW);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  swm_pkg::state_e                  state_q, state_d;
  logic [AW-1:0]                    head_q, head_d;
  logic [AW-1:0]                    tail_q, tail_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [swm_pkg::POS_W-1:0]        idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  swm_pkg::entry_t                  front_q, front_d;
  logic signed [swm_pkg::DATA_W-1:0] s_q, s_d;
  logic                             last_q, last_d;
  swm_pkg::result_t                 result_q, result_d;
  logic [swm_pkg::POS_W-1:0]        win_q, win_d;

  logic                             accept;
  logic [swm_pkg::POS_W-1:0]        next_pos;
  logic [swm_pkg::POS_W-1:0]        win_ext;
  logic [AW-1:0]                    tail_prev;
  swm_pkg::entry_t                  new_entry;

  assign next_pos  = idx_q + swm_pkg::POS_W'(1);
  assign win_ext   = swm_pkg::POS_W'(win_len_i);
  assign tail_prev = ring_prev(tail_q);
  assign new_entry = '{value: s_q, pos: idx_q};

  assign in_ready_o = (state_q == swm_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    front_d       = front_q;
    s_d           = s_q;
    last_d        = last_q;
    result_d      = result_q;
    win_d         = win_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = tail_q;
    mem_wdata_o   = new_entry;
    mem_re_a_o    = 1'b0;
    mem_raddr_a_o = ring_next(head_q);
    mem_re_b_o    = 1'b0;
    mem_raddr_b_o = tail_prev;

    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          result_d.window_empty = (count_q == '0);
          result_d.window_min   = (count_q == '0) ? '0 : front_q.value;
          s_d        = sample_i;
          last_d     = end_of_stream_i;
          // The window is held for the whole item, so a later write only
          // affects the next one.
          win_d      = win_ext;
          // The back entry is fetched now; front drops leave the tail alone.
          mem_re_b_o = 1'b1;
          if ((count_q != '0) && ((next_pos - front_q.pos) > win_ext)) begin
            head_d     = ring_next(head_q);
            count_d    = count_q - CW'(1);
            mem_re_a_o = 1'b1;
            state_d    = swm_pkg::ST_FRONT;
          end else begin
            state_d = swm_pkg::ST_BACK;
          end
        end
      end

      swm_pkg::ST_FRONT: begin
        // The entry now at the head has just been read; it becomes the cache.
        front_d = mem_rdata_a_i;
        if ((count_q != '0) && ((next_pos - mem_rdata_a_i.pos) > win_q)) begin
          head_d     = ring_next(head_q);
          count_d    = count_q - CW'(1);
          mem_re_a_o = 1'b1;
        end else begin
          state_d = swm_pkg::ST_BACK;
        end
      end

      swm_pkg::ST_BACK: begin
        if ((count_q != '0) && ($signed(mem_rdata_b_i.value) >= $signed(s_q))) begin
          tail_d        = tail_prev;
          count_d       = count_q - CW'(1);
          mem_re_b_o    = 1'b1;
          mem_raddr_b_o = ring_prev(tail_prev);
        end else begin
          if (count_q != FULL) begin
            mem_we_o = 1'b1;
            tail_d   = ring_next(tail_q);
            count_d  = count_q + CW'(1);
            if (count_q == '0) begin
              front_d = new_entry;
            end
          end
          idx_d   = next_pos;
          state_d = swm_pkg::ST_IDLE;
          if (last_q) begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
            idx_d   = '0;
          end
        end
      end

      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q  <= front_d;
    s_q      <= s_d;
    last_q   <= last_d;
    result_q <= result_d;
    win_q    <= win_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule : swm_ctrl

`default_nettype wire

FILE: src/sliding_window_min_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_unit: running minimum over a sliding window
// For each sample gives the minimum of the preceding window_length samples
// of the same stream, kept in a monotonic deque held in memory.
// ----------------------------------------------------------------------------
// An item is handled in the idle state, then in the front state while entries
// leave the front of the deque because they fall out of the window (this state
// is skipped if none does), then in the back state while entries leave its
// back because they are not below the new sample. Each drop waits for the next
// entry to be read from the deque memory, whose reads are registered. The
// result of an item is registered as soon as the item is accepted and appears
// in the next cycle; a new item is taken only once the block is idle and that
// result has been accepted, or is accepted in the same cycle. A window length
// written while an item is being processed applies from the next item. The
// deque needs no clearing after reset.
module sliding_window_min_unit #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [swm_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [swm_pkg::DATA_W-1:0]  sample_i,
  input  wire logic                               end_of_stream_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [swm_pkg::DATA_W-1:0]       window_min_o,
  output logic                                    window_empty_o
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  logic [swm_pkg::CFG_W-1:0] win_cfg_q;
  logic [31:0]               cfg_ext;
  logic [CW-1:0]             win_len;
  swm_pkg::result_t          result;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  swm_pkg::entry_t           mem_wdata;
  logic                      mem_re_a;
  logic [AW-1:0]             mem_raddr_a;
  swm_pkg::entry_t           mem_rdata_a;
  logic                      mem_re_b;
  logic [AW-1:0]             mem_raddr_b;
  swm_pkg::entry_t           mem_rdata_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= swm_pkg::CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_cfg_q <= cfg_data_i;
    end
  end

  // A window of zero acts as one, and one beyond the deque depth as the depth.
  assign cfg_ext = 32'(win_cfg_q);
  always_comb begin
    priority if (cfg_ext == 32'd0) begin
      win_len = CW'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      win_len = CW'(MAX_WINDOW);
    end else begin
      win_len = CW'(cfg_ext);
    end
  end

  swm_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_len_i       (win_len),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_a_o      (mem_re_a),
    .mem_raddr_a_o   (mem_raddr_a),
    .mem_rdata_a_i   (mem_rdata_a),
    .mem_re_b_o      (mem_re_b),
    .mem_raddr_b_o   (mem_raddr_b),
    .mem_rdata_b_i   (mem_rdata_b)
  );

  swm_mem #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_a_i    (mem_re_a),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .re_b_i    (mem_re_b),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

  assign window_min_o   = result.window_min;
  assign window_empty_o = result.window_empty;

endmodule : sliding_window_min_unit

`default_nettype wire

FILE: tb/swm_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_check_pkg: expected results for the sliding window minimum testbench
// Keeps its own monotonic deque of the current stream and works out the
// minimum and the empty flag for every accepted sample item, then compares
// each result item from the block with the oldest one still waiting.
// ----------------------------------------------------------------------------
package swm_check_pkg;

  import swm_pkg::*;

  localparam int unsigned DEPTH      = 1024;

  class window_min_tracker;

    entry_t           live[$];
    result_t          pending_mins[$];
    logic [POS_W-1:0] stream_pos;
    logic [CFG_W-1:0] win_len;
    int unsigned      errors;

    function new();
      stream_pos = '0;
      win_len    = CFG_W'(1);
      errors     = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] len);
      win_len = len;
    endfunction

    function int unsigned outstanding();
      return pending_mins.size();
    endfunction

    function void report(string what, logic signed [DATA_W-1:0] want,
                         logic signed [DATA_W-1:0] got);
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d",
               $time, what, want, got);
    endfunction

    // One sample item: the answer comes from the deque as it stands, and
    // only then is the deque brought up to date for the next sample.
    function void note_sample(logic signed [DATA_W-1:0] s, logic last);
      result_t          r;
      entry_t           e;
      logic [POS_W-1:0] span;
      logic [POS_W-1:0] upcoming;
      if (win_len == '0) begin
        span = POS_W'(1);
      end else if (win_len > DEPTH) begin
        span = POS_W'(DEPTH);
      end else begin
        span = POS_W'(win_len);
      end
      r.window_empty = (live.size() == 0);
      r.window_min   = r.window_empty ? '0 : live[0].value;
      pending_mins.push_back(r);

      upcoming = stream_pos + 1;
      while (live.size() > 0 && (upcoming - live[0].pos) > span) begin
        void'(live.pop_front());
      end
      while (live.size() > 0 && $signed(live[$].value) >= $signed(s)) begin
        void'(live.pop_back());
      end
      if (live.size() < DEPTH) begin
        e.value = s;
        e.pos   = stream_pos;
        live.push_back(e);
      end
      stream_pos = upcoming;

      if (last) begin
        live.delete();
        stream_pos = '0;
      end
    endfunction

    function void check_min(logic signed [DATA_W-1:0] got_min, logic got_empty);
      result_t want;
      if (pending_mins.size() == 0) begin
        report("unexpected result, window_min", '0, got_min);
        return;
      end
      want = pending_mins.pop_front();
      if (got_min !== want.window_min) begin
        report("window_min", want.window_min, got_min);
      end
      if (got_empty !== want.window_empty) begin
        report("window_empty", DATA_W'(want.window_empty), DATA_W'(got_empty));
      end
    endfunction

  endclass

endpackage : swm_check_pkg

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sliding window minimum unit
// Drives sample items and window lengths through the valid/ready channels,
// with random gaps and stalls on both sides, and checks every result item
// against an independent deque-based prediction.
// ----------------------------------------------------------------------------
module tb_top;

  import swm_pkg::*;
  import swm_check_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RANDOM_ITEMS  = 1030;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
  localparam int unsigned STALL_LIMIT   = 20000;

  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;

  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_RISING,
    PAT_FALLING,
    PAT_EXTREME
  } pattern_e;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_W-1:0]         cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic signed [DATA_W-1:0] sample    = '0;
  logic                     eos       = 1'b0;
  logic                     out_ready = 1'b0;

  wire                        cfg_ready;
  wire                        in_ready;
  wire                        out_valid;
  wire signed [DATA_W-1:0]    window_min;
  wire                        window_empty;

  window_min_tracker tracker;

  bit          src_idle     = 1'b1;
  bit          snk_idle     = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned idle_cycles  = 0;

  // State of the sample pattern generator.
  pattern_e                 pattern   = PAT_RANDOM;
  int unsigned              run_left  = 0;
  int unsigned              max_run   = 16;
  logic signed [DATA_W-1:0] ramp_val  = '0;
  logic signed [DATA_W-1:0] ramp_step = '0;

  sliding_window_min_unit #(
    .MAX_WINDOW(DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_i       (sample),
    .end_of_stream_i(eos),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .window_min_o   (window_min),
    .window_empty_o (window_empty)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Everything is sampled at the edge, before this edge's drives land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.check_min(window_min, window_empty);
      end
      if (in_valid && in_ready) begin
        tracker.note_sample(sample, eos);
      end
      if (cfg_valid && cfg_ready) begin
        tracker.set_window(cfg_data);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: a random stall before each item while snk_idle is set, and on
  // request one long hold-off so that the block fills up and stops taking samples.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = snk_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    eos      <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // The sender stops until every result is back, then lets the block finish
  // any front and back drops that may still be running.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] draw_sample();
    logic signed [DATA_W-1:0] v;
    if (run_left == 0) begin
      pattern   = pattern_e'($urandom_range(PAT_RANDOM, PAT_EXTREME));
      run_left  = $urandom_range(1, max_run);
      ramp_val  = $urandom;
      ramp_step = $urandom_range(1, 1 << 16);
    end
    run_left--;
    case (pattern)
      PAT_RANDOM: begin
        v = $urandom;
      end
      PAT_NARROW: begin
        v = int'($urandom_range(0, 6)) - 3;
      end
      PAT_RISING: begin
        ramp_val = ramp_val + ramp_step;
        v = ramp_val;
      end
      PAT_FALLING: begin
        ramp_val = ramp_val - ramp_step;
        v = ramp_val;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      count;
    int unsigned      eos_spread;
    logic [CFG_W-1:0] len;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the sample, equal values, falling and rising runs, a stream
    // of one sample and a window change in the middle of a stream.
    write_window(CFG_W'(3));
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(4, 1'b0);
    send_sample(3, 1'b0);
    send_sample(2, 1'b0);
    send_sample(10, 1'b0);
    send_sample(11, 1'b0);
    send_sample(12, 1'b0);
    send_sample(13, 1'b1);
    send_sample(42, 1'b1);
    send_sample(9, 1'b0);
    send_sample(-9, 1'b0);
    finish_phase();
    // A zero window behaves as a window of one.
    write_window('0);
    send_sample(8, 1'b0);
    send_sample(-8, 1'b0);
    send_sample(8, 1'b1);
    send_sample(8, 1'b0);
    finish_phase();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: len = CFG_W'(DEPTH);
        1: len = '1;
        2: len = CFG_W'(1);
        3: len = '0;
        4: len = CFG_W'(DEPTH + 1);
        default: begin
          case ($urandom_range(0, 9))
            0: len = CFG_W'($urandom_range(DEPTH, (1 << CFG_W) - 1));
            1: len = CFG_W'($urandom_range(0, 1));
            2: len = CFG_W'($urandom_range(200, DEPTH - 1));
            default: len = CFG_W'($urandom_range(2, 48));
          endcase
        end
      endcase
      write_window(len);

      if (len >= 512) begin
        count   = $urandom_range(120, 250);
        max_run = 250;
      end else begin
        count   = $urandom_range(20, 80);
        max_run = 24;
      end
      if (count > RANDOM_ITEMS - sent) begin
        count = RANDOM_ITEMS - sent;
      end
      case ($urandom_range(0, 2))
        0: eos_spread = 6;
        1: eos_spread = 50;
        default: eos_spread = 500;
      endcase
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        src_idle     = 1'b0;
        hold_request = 1'b1;
      end

      repeat (count) begin
        send_sample(draw_sample(), $urandom_range(0, eos_spread) == 0);
        sent++;
      end
      finish_phase();
      phase++;
    end

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_top
